/* rtl/arfp_pkg.sv */
`default_nettype none

package arfp_pkg;

   localparam int DISTANCE_BITS_DEFAULT = 14;
   localparam int DIST_OUT_BITS         = 14;
   localparam int DIGITS_BITS           = 4;
   localparam int BYTE_BITS             = 8;
   localparam int CSR_INDEX_BITS        = 2;
   localparam int CSR_DATA_BITS         = 14;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DISTANCE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DIGITS   = 2'd1;

   localparam logic [DIST_OUT_BITS-1:0] MAX_DISTANCE_RESET = 14'd10000;
   localparam logic [DIGITS_BITS-1:0]   MAX_DIGITS_RESET   = 4'd14;

   localparam logic [DIGITS_BITS-1:0] DIGIT_LIMIT = 4'd14;
   localparam logic [DIGITS_BITS-1:0] COUNT_SAT   = 4'd15;

   localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_M     = 8'h6D;
   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;

   typedef struct packed {
      logic [DIST_OUT_BITS-1:0] max_distance;
      logic [DIGITS_BITS-1:0]   max_digits;
   } parser_cfg_type;

   typedef struct packed {
      logic                     hit;
      logic [DIST_OUT_BITS-1:0] distance;
   } parse_result_type;

endpackage

`default_nettype wire

/* rtl/arfp_parser.sv */
`default_nettype none

module arfp_parser
   import arfp_pkg::*;
#(
   parameter int DISTANCE_BITS = DISTANCE_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic [BYTE_BITS-1:0] rx_byte,
   input  wire parser_cfg_type       cfg,
   output parse_result_type          result
);

   localparam int NEXT_W = DISTANCE_BITS + 4;
   localparam int WIDE_W = (DISTANCE_BITS > DIST_OUT_BITS) ? DISTANCE_BITS : DIST_OUT_BITS;

   typedef enum logic [2:0] {
      PH_UNSYNCED = 3'd0,
      PH_NUMBER   = 3'd1,
      PH_SPACE    = 3'd2,
      PH_M1       = 3'd3,
      PH_M2       = 3'd4,
      PH_CR       = 3'd5,
      PH_LF       = 3'd6
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [DISTANCE_BITS-1:0] value_ff, value_in;
   logic [DIGITS_BITS-1:0]   count_ff, count_in;
   logic                     over_ff, over_in;
   logic                     ok_ff, ok_in;

   logic                     is_digit;
   logic [NEXT_W-1:0]        next_value;
   logic                     next_over;
   logic [WIDE_W-1:0]        value_wide;
   logic                     value_fits;

   assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign next_value = (NEXT_W'(value_ff) << 3) + (NEXT_W'(value_ff) << 1)
                       + NEXT_W'(rx_byte[3:0]);
   assign next_over  = over_ff || (|next_value[NEXT_W-1:DISTANCE_BITS]);
   assign value_wide = WIDE_W'(value_ff);
   assign value_fits = value_wide <= WIDE_W'(cfg.max_distance);

   assign result.hit      = (phase_ff == PH_CR) && (rx_byte == CHAR_LF) && ok_ff;
   assign result.distance = value_wide[DIST_OUT_BITS-1:0];

   always_comb begin
      logic do_resync;
      do_resync = 1'b0;
      phase_in  = phase_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      over_in   = over_ff;
      ok_in     = ok_ff;
      case (phase_ff)
         PH_NUMBER: begin
            if (is_digit) begin
               if (next_over) begin
                  over_in  = 1'b1;
                  value_in = '1;
               end else begin
                  value_in = next_value[DISTANCE_BITS-1:0];
               end
               if (count_ff != COUNT_SAT) begin
                  count_in = count_ff + 1'b1;
               end
            end else if (rx_byte == CHAR_SPACE) begin
               ok_in = (count_ff != '0) && (count_ff <= DIGIT_LIMIT)
                       && (count_ff <= cfg.max_digits) && !over_ff && value_fits;
               phase_in = PH_SPACE;
            end else begin
               ok_in    = 1'b0;
               phase_in = PH_UNSYNCED;
            end
         end
         PH_SPACE: begin
            if (rx_byte == CHAR_M) begin
               phase_in = PH_M1;
            end else begin
               do_resync = 1'b1;
            end
         end
         PH_M1: begin
            if (rx_byte == CHAR_M) begin
               phase_in = PH_M2;
            end else begin
               do_resync = 1'b1;
            end
         end
         PH_M2: begin
            if (rx_byte == CHAR_CR) begin
               phase_in = PH_CR;
            end else if (rx_byte != CHAR_M) begin
               do_resync = 1'b1;
            end
         end
         PH_CR: begin
            if (rx_byte == CHAR_LF) begin
               ok_in    = 1'b0;
               phase_in = PH_LF;
            end else begin
               do_resync = 1'b1;
            end
         end
         default: begin
            do_resync = 1'b1;
         end
      endcase
      if (do_resync) begin
         ok_in = 1'b0;
         if (is_digit) begin
            value_in = DISTANCE_BITS'(rx_byte[3:0]);
            count_in = DIGITS_BITS'(1);
            over_in  = 1'b0;
            phase_in = PH_NUMBER;
         end else begin
            phase_in = PH_UNSYNCED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_UNSYNCED;
         value_ff <= '0;
         count_ff <= '0;
         over_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         value_ff <= value_in;
         count_ff <= count_in;
         over_ff  <= over_in;
         ok_ff    <= ok_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ascii_range_frame_parser.sv */
`default_nettype none

// Parses a rangefinder text stream of digits followed by " mm" (extra 'm' allowed), CR and LF,
// one byte per item, and returns the distance in millimetres on the LF of a frame whose digit
// count and value are within csr limits. One byte is taken every cycle while no result is
// stalled; a result is registered (the LF byte lands in the input register, then the parser
// step loads the result register). req_ready follows rsp_ready through the single input
// register, so a stalled result still lets one more byte in. Configuration writes are to be
// made only while the block is idle.
module ascii_range_frame_parser
   import arfp_pkg::*;
#(
   parameter int DISTANCE_BITS = DISTANCE_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [BYTE_BITS-1:0]      req_rx_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [DIST_OUT_BITS-1:0]       rsp_distance_mm,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   parser_cfg_type           cfg_ff;
   logic                     in_valid_ff;
   logic [BYTE_BITS-1:0]     in_byte_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DIST_OUT_BITS-1:0] rsp_distance_ff;
   logic                     advance;
   parse_result_type         result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_mm = rsp_distance_ff;
   assign rsp_valid_in    = advance ? result.hit : (rsp_valid_ff && !rsp_ready);

   arfp_parser #(
      .DISTANCE_BITS(DISTANCE_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_distance <= MAX_DISTANCE_RESET;
         cfg_ff.max_digits   <= MAX_DIGITS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_DISTANCE: cfg_ff.max_distance <= csr_wdata[DIST_OUT_BITS-1:0];
            CSR_MAX_DIGITS:   cfg_ff.max_digits   <= csr_wdata[DIGITS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && result.hit) begin
         rsp_distance_ff <= result.distance;
      end
   end

endmodule

`default_nettype wire

/* rtl/arfp_checker.sv */
`default_nettype none

module arfp_checker
   import arfp_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic [BYTE_BITS-1:0]      req_rx_byte,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [DIST_OUT_BITS-1:0]  rsp_distance_mm,
   input wire logic                      csr_write_en,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_rx_byte, csr_write_en, csr_index, csr_wdata};

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a waiting result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_mm))
      else $error("stalled result changed or dropped");

   // input side never blocks unless a result is waiting
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no result waiting");

endmodule

bind ascii_range_frame_parser arfp_checker u_arfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_rx_byte     (req_rx_byte),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_distance_mm (rsp_distance_mm),
   .csr_write_en    (csr_write_en),
   .csr_index       (csr_index),
   .csr_wdata       (csr_wdata)
);

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
   import arfp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int DIST_BITS     = DISTANCE_BITS_DEFAULT;
   localparam int unsigned ACC_MAX = (1 << DIST_BITS) - 1;
   localparam int SETTLE_CYCLES = 5;
   localparam int LONG_HOLD     = 300;
   localparam int PRINT_CAP     = 50;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic [2:0] {
      PH_UNSYNCED,
      PH_NUMBER,
      PH_SPACE,
      PH_M1,
      PH_M2,
      PH_CR,
      PH_LF
   } parse_phase_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [BYTE_BITS-1:0]      req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DIST_OUT_BITS-1:0]  rsp_distance_mm;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // parser mirror
   parse_phase_type           parse_state = PH_UNSYNCED;
   logic [DIST_BITS-1:0]      acc_value = '0;
   logic [DIGITS_BITS-1:0]    acc_digits = '0;
   bit                        acc_over = 1'b0;
   bit                        frame_ok = 1'b0;
   logic [DIST_OUT_BITS-1:0]  lim_distance = MAX_DISTANCE_RESET;
   logic [DIGITS_BITS-1:0]    lim_digits = MAX_DIGITS_RESET;

   logic [BYTE_BITS-1:0]      rx_byte_q[$];
   logic [BYTE_BITS-1:0]      frame_buf[$];
   logic [DIST_OUT_BITS-1:0]  distance_exp_q[$];

   bit                        idle_on = 1'b0;
   int                        send_gap = 0;
   int                        rsp_stall = 0;
   int                        dist_seen = 0;
   int                        mismatch_count = 0;

   ascii_range_frame_parser #(
      .DISTANCE_BITS(DIST_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_distance_mm(rsp_distance_mm),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   function automatic bit is_digit(logic [BYTE_BITS-1:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic void restart_on(logic [BYTE_BITS-1:0] b);
      frame_ok = 1'b0;
      if (is_digit(b)) begin
         acc_value   = b - CHAR_ZERO;
         acc_digits  = 1;
         acc_over    = 1'b0;
         parse_state = PH_NUMBER;
      end else begin
         parse_state = PH_UNSYNCED;
      end
   endfunction

   function automatic void parse_byte(logic [BYTE_BITS-1:0] b);
      int unsigned next_val;
      case (parse_state)
         PH_NUMBER: begin
            if (is_digit(b)) begin
               next_val = int'(acc_value) * 10 + int'(b) - int'(CHAR_ZERO);
               if (acc_over || next_val > ACC_MAX) begin
                  acc_over  = 1'b1;
                  acc_value = ACC_MAX;
               end else begin
                  acc_value = next_val[DIST_BITS-1:0];
               end
               if (acc_digits < COUNT_SAT) acc_digits++;
            end else if (b == CHAR_SPACE) begin
               frame_ok = acc_digits >= 1 && acc_digits <= DIGIT_LIMIT &&
                          acc_digits <= lim_digits && !acc_over &&
                          acc_value <= lim_distance;
               parse_state = PH_SPACE;
            end else begin
               frame_ok    = 1'b0;
               parse_state = PH_UNSYNCED;
            end
         end
         PH_SPACE: if (b == CHAR_M) parse_state = PH_M1; else restart_on(b);
         PH_M1: if (b == CHAR_M) parse_state = PH_M2; else restart_on(b);
         PH_M2: begin
            if (b == CHAR_CR) parse_state = PH_CR;
            else if (b != CHAR_M) restart_on(b);
         end
         PH_CR: begin
            if (b == CHAR_LF) begin
               if (frame_ok) distance_exp_q.push_back(acc_value[DIST_OUT_BITS-1:0]);
               frame_ok    = 1'b0;
               parse_state = PH_LF;
            end else begin
               restart_on(b);
            end
         end
         default: restart_on(b);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sender
   always @(posedge clock) begin : drive_proc
      bit fire;
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= '0;
         send_gap    <= 0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) parse_byte(req_rx_byte);
         if (!req_valid || fire) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (rx_byte_q.size() > 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_byte_q.pop_front();
               send_gap    <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : sink_proc
      logic [DIST_OUT_BITS-1:0] want;
      int stall_next;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
         dist_seen <= 0;
      end else begin
         stall_next = rsp_stall;
         if (rsp_valid && rsp_ready) begin
            if (distance_exp_q.size() == 0) begin
               report_mismatch($sformatf("unexpected distance %0d", rsp_distance_mm));
            end else begin
               want = distance_exp_q.pop_front();
               if (rsp_distance_mm !== want) begin
                  report_mismatch($sformatf("distance %0d, want %0d", rsp_distance_mm, want));
               end
            end
            dist_seen <= dist_seen + 1;
            if (dist_seen == 24 || dist_seen == 90) stall_next = LONG_HOLD;
         end
         if (stall_next > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall <= stall_next - 1;
         end else if (idle_on && $urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            rsp_stall <= pick_gap();
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall <= 0;
         end
      end
   end

   function automatic void push_frame(string digits, int m_count);
      foreach (digits[i]) frame_buf.push_back(digits[i]);
      frame_buf.push_back(CHAR_SPACE);
      repeat (m_count) frame_buf.push_back(CHAR_M);
      frame_buf.push_back(CHAR_CR);
      frame_buf.push_back(CHAR_LF);
   endfunction

   function automatic int pick_value();
      int r = $urandom_range(0, 99);
      if (r < 10) return int'(lim_distance);
      if (r < 15) return int'(lim_distance) + 1;
      if (r < 20) return ACC_MAX;
      if (r < 25) return ACC_MAX + 1;
      if (r < 30) return 0;
      if (r < 40) return $urandom_range(0, 9);
      return $urandom_range(0, 17000);
   endfunction

   function automatic void build_frame();
      string txt;
      int m_extra;
      if ($urandom_range(0, 99) < 15) begin
         // long digit runs: count saturation and accumulator overflow
         txt = $sformatf("%0d%0d", $urandom, $urandom);
         txt = txt.substr(0, $urandom_range(0, txt.len() - 1));
      end else begin
         txt = $sformatf("%0d", pick_value());
         if ($urandom_range(0, 99) < 10) txt = {"0", txt};
      end
      m_extra = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
      push_frame(txt, 2 + m_extra);
   endfunction

   function automatic void corrupt_frame();
      int cut = $urandom_range(0, frame_buf.size() - 1);
      if ($urandom_range(0, 1)) begin
         frame_buf[cut] = BYTE_BITS'($urandom_range(0, 255));
      end else begin
         while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
   endfunction

   function automatic void queue_random(int count);
      int pushed = 0;
      int k;
      while (pushed < count) begin
         frame_buf.delete();
         k = $urandom_range(0, 99);
         if (k < 72) begin
            build_frame();
         end else if (k < 87) begin
            build_frame();
            corrupt_frame();
         end else begin
            repeat ($urandom_range(1, 4)) frame_buf.push_back(BYTE_BITS'($urandom_range(0, 255)));
         end
         foreach (frame_buf[i]) rx_byte_q.push_back(frame_buf[i]);
         pushed += frame_buf.size();
      end
   endfunction

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_MAX_DISTANCE: lim_distance = data[DIST_OUT_BITS-1:0];
         CSR_MAX_DIGITS: lim_digits = data[DIGITS_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (rx_byte_q.size() != 0 || req_valid || distance_exp_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int count, bit idle);
      @(negedge clock);
      idle_on = idle;
      queue_random(count);
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // short directed frames at reset limits
      @(negedge clock);
      frame_buf.delete();
      push_frame("0", 2);
      push_frame("10000", 3);
      push_frame("9", 2);
      frame_buf.push_back(CHAR_ZERO + 5);
      frame_buf.push_back(8'hB5);
      foreach (frame_buf[i]) rx_byte_q.push_back(frame_buf[i]);
      wait_idle();

      write_csr(CSR_MAX_DISTANCE, 14'd16383);
      write_csr(CSR_MAX_DIGITS, 14'd14);
      run_phase(400, 1'b1);

      write_csr(CSR_MAX_DISTANCE, 14'd0);
      write_csr(CSR_MAX_DIGITS, 14'd1);
      run_phase(250, 1'b0);

      write_csr(CSR_MAX_DIGITS, 14'd0);
      write_csr(CSR_MAX_DISTANCE, 14'd500);
      run_phase(150, 1'b1);

      write_csr(CSR_SPARE_A, CSR_DATA_BITS'($urandom_range(0, 16383)));
      write_csr(CSR_SPARE_B, CSR_DATA_BITS'($urandom_range(0, 16383)));
      write_csr(CSR_MAX_DISTANCE, CSR_DATA_BITS'($urandom_range(0, 16383)));
      write_csr(CSR_MAX_DIGITS, {10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15))});
      run_phase(450, 1'b1);

      write_csr(CSR_MAX_DISTANCE, 14'd10000);
      write_csr(CSR_MAX_DIGITS, 14'd5);
      run_phase(550, 1'b1);

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
